// File: rtl/rfsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfsp_pkg
// Types and constants of the RESP frame stream parser: parse modes, status
// and element codes, digit tracking codes and the bytes the grammar uses.
// ----------------------------------------------------------------------------
package rfsp_pkg;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int TYPE_W      = 3;
    localparam int VALUE_W     = 64;
    localparam int DEPTH_OUT_W = 5;

    typedef logic [BYTE_W-1:0]      t_byte;
    typedef logic [STATUS_W-1:0]    t_status;
    typedef logic [TYPE_W-1:0]      t_elem;
    typedef logic [VALUE_W-1:0]     t_value;
    typedef logic [DEPTH_OUT_W-1:0] t_depth_out;

    typedef enum logic [3:0] {
        MODE_TAG     = 4'd0,
        MODE_SIMPLE  = 4'd1,
        MODE_ERROR   = 4'd2,
        MODE_INT     = 4'd3,
        MODE_BULKLEN = 4'd4,
        MODE_NULL    = 4'd5,
        MODE_BODY    = 4'd6,
        MODE_TAIL1   = 4'd7,
        MODE_TAIL2   = 4'd8,
        MODE_ARRAY   = 4'd9
    } t_mode;

    typedef enum logic [1:0] {
        PH_NONE    = 2'd0,
        PH_DIGITS  = 2'd1,
        PH_AFTER   = 2'd2,
        PH_INVALID = 2'd3
    } t_phase;

    localparam t_status ST_BUSY       = 3'd0;
    localparam t_status ST_ELEM_DONE  = 3'd1;
    localparam t_status ST_FRAME_DONE = 3'd2;
    localparam t_status ST_BAD_TAG    = 3'd3;
    localparam t_status ST_BAD_NUM    = 3'd4;
    localparam t_status ST_BAD_NULL   = 3'd5;
    localparam t_status ST_TOO_DEEP   = 3'd6;

    localparam t_elem ET_SIMPLE  = 3'd0;
    localparam t_elem ET_ERROR   = 3'd1;
    localparam t_elem ET_INTEGER = 3'd2;
    localparam t_elem ET_BULK    = 3'd3;
    localparam t_elem ET_NULL    = 3'd4;
    localparam t_elem ET_ARRAY   = 3'd5;

    localparam t_byte CH_PLUS   = 8'h2B;
    localparam t_byte CH_MINUS  = 8'h2D;
    localparam t_byte CH_COLON  = 8'h3A;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_ONE    = 8'h31;
    localparam t_byte CH_NINE   = 8'h39;

endpackage
`default_nettype wire

// File: rtl/rfsp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfsp channel interfaces
// Valid/ready channels of the parser: the byte stream in, one result per
// byte out.
// ----------------------------------------------------------------------------
interface rfsp_in_if;
    logic                 valid;
    logic                 ready;
    rfsp_pkg::t_byte      stream_byte;

    modport source(output valid, output stream_byte, input ready);
    modport sink(input valid, input stream_byte, output ready);
endinterface

interface rfsp_out_if;
    logic                 valid;
    logic                 ready;
    rfsp_pkg::t_status    status;
    rfsp_pkg::t_elem      elem_type;
    rfsp_pkg::t_value     value;
    rfsp_pkg::t_depth_out nest_depth;
    logic                 payload_valid;

    modport source(output valid, output status, output elem_type, output value,
                   output nest_depth, output payload_valid, input ready);
    modport sink(input valid, input status, input elem_type, input value,
                 input nest_depth, input payload_valid, output ready);
endinterface
`default_nettype wire

// File: rtl/rfsp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfsp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: rtl/resp_frame_stream_parser_top.sv
// output: a byte's result sits in the output register in the cycle after its transfer
// throughput: one byte per cycle while the output is not held, including array pops of any depth
// the count stack lives in a one-port-read ram; the top entry is held in a register,
//   and a pop refills it from the ram in the cycle after, while the parser expects a tag
// reset: synchronous active low; parser back to expect-tag, depth zero, output empty;
//   the stack ram is not cleared and needs no clearing pass
`default_nettype none
// ----------------------------------------------------------------------------
// resp_frame_stream_parser_top
// RESP2 frame checker: one stream byte in, one status result out, array
// nesting tracked on a count stack in RAM.
// ----------------------------------------------------------------------------
module resp_frame_stream_parser_top #(
    parameter int MAX_DEPTH = 16
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    rfsp_in_if.sink   i_byte,
    rfsp_out_if.source o_res
);

    localparam int DW    = $clog2(MAX_DEPTH + 1);
    localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ENT_W = rfsp_pkg::VALUE_W + DW;
    localparam logic [DW-1:0] MAX_D = DW'(MAX_DEPTH);
    localparam logic [DW-1:0] ONE_D = DW'(1);

    // parser state
    rfsp_pkg::t_mode  r_mode,  n_mode;
    rfsp_pkg::t_phase r_phase, n_phase;
    rfsp_pkg::t_value r_acc,   n_acc;
    rfsp_pkg::t_value r_bulk,  n_bulk;
    rfsp_pkg::t_elem  r_type,  n_type;
    logic             r_ovf,   n_ovf;
    logic             r_saw_cr, n_saw_cr;

    // stack: depth, cached top entry, refill flag
    logic [DW-1:0]    r_depth, n_depth;
    rfsp_pkg::t_value r_top_cnt, n_top_cnt;
    logic [DW-1:0]    r_top_chain, n_top_chain;
    logic             r_load_pend, n_load_pend;

    // output register
    logic                 r_out_valid;
    rfsp_pkg::t_status    r_out_status;
    rfsp_pkg::t_elem      r_out_type;
    rfsp_pkg::t_value     r_out_value;
    rfsp_pkg::t_depth_out r_out_depth;
    logic                 r_out_pay;

    rfsp_pkg::t_status    res_status;
    rfsp_pkg::t_value     res_value;
    logic                 res_pay;

    logic                 w_accept;
    rfsp_pkg::t_byte      w_b;
    logic                 w_is_digit;
    logic [3:0]           w_d;
    logic [rfsp_pkg::VALUE_W+3:0] w_prod;
    logic                 w_ovf_now;
    logic                 w_numeric;
    rfsp_pkg::t_phase     w_ph;
    logic [DW-1:0]        w_dm1;
    logic [DW-1:0]        w_newdepth;
    logic [DW-1:0]        w_newdm1;
    logic [DW+4:0]        w_depth_ext;
    logic                 do_elem_done;
    logic                 do_to_top;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENT_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [ENT_W-1:0]     ram_rdata;

    rfsp_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_DEPTH)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_byte.ready = !r_out_valid || o_res.ready;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_b          = i_byte.stream_byte;

    // decimal step: acc * 10 + digit, carry-out above 64 bits is overflow
    assign w_is_digit = (w_b >= rfsp_pkg::CH_ZERO) && (w_b <= rfsp_pkg::CH_NINE);
    assign w_d        = 4'(w_b - rfsp_pkg::CH_ZERO);
    assign w_prod     = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                      + {{rfsp_pkg::VALUE_W{1'b0}}, w_d};
    assign w_ovf_now  = |w_prod[rfsp_pkg::VALUE_W+3:rfsp_pkg::VALUE_W];

    assign w_numeric = (r_mode == rfsp_pkg::MODE_INT) || (r_mode == rfsp_pkg::MODE_BULKLEN)
                    || (r_mode == rfsp_pkg::MODE_ARRAY);

    assign w_dm1      = r_depth - ONE_D;
    assign w_newdepth = r_depth - ONE_D - r_top_chain;
    assign w_newdm1   = w_newdepth - ONE_D;

    // phase after a held cr turns out to be content
    always_comb begin
        w_ph = r_phase;
        if (r_saw_cr) begin
            if (r_mode == rfsp_pkg::MODE_NULL) begin
                w_ph = rfsp_pkg::PH_INVALID;
            end else if (w_numeric) begin
                case (r_phase)
                    rfsp_pkg::PH_NONE:   w_ph = rfsp_pkg::PH_INVALID;
                    rfsp_pkg::PH_DIGITS: w_ph = rfsp_pkg::PH_AFTER;
                    default:             w_ph = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_bulk      = r_bulk;
        n_type      = r_type;
        n_ovf       = r_ovf;
        n_saw_cr    = r_saw_cr;
        n_depth     = r_depth;
        n_top_cnt   = r_top_cnt;
        n_top_chain = r_top_chain;
        n_load_pend = 1'b0;
        res_status  = rfsp_pkg::ST_BUSY;
        res_value   = '0;
        res_pay     = 1'b0;
        do_elem_done = 1'b0;
        do_to_top    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = w_dm1[AW-1:0];
        ram_wdata   = {r_top_cnt, r_top_chain};
        ram_re      = 1'b0;
        ram_raddr   = w_newdm1[AW-1:0];

        // refill of the top entry after a pop; the byte in this cycle is a tag
        if (r_load_pend) begin
            n_top_cnt   = ram_rdata[ENT_W-1:DW] - rfsp_pkg::t_value'(1);
            n_top_chain = ram_rdata[DW-1:0];
        end

        if (w_accept) begin
            case (r_mode)
                rfsp_pkg::MODE_TAG: begin
                    n_acc    = '0;
                    n_phase  = rfsp_pkg::PH_NONE;
                    n_ovf    = 1'b0;
                    n_saw_cr = 1'b0;
                    n_bulk   = '0;
                    case (w_b)
                        rfsp_pkg::CH_PLUS: begin
                            n_type = rfsp_pkg::ET_SIMPLE;
                            n_mode = rfsp_pkg::MODE_SIMPLE;
                        end
                        rfsp_pkg::CH_MINUS: begin
                            n_type = rfsp_pkg::ET_ERROR;
                            n_mode = rfsp_pkg::MODE_ERROR;
                        end
                        rfsp_pkg::CH_COLON: begin
                            n_type = rfsp_pkg::ET_INTEGER;
                            n_mode = rfsp_pkg::MODE_INT;
                        end
                        rfsp_pkg::CH_DOLLAR: begin
                            n_type = rfsp_pkg::ET_BULK;
                            n_mode = rfsp_pkg::MODE_BULKLEN;
                        end
                        rfsp_pkg::CH_STAR: begin
                            n_type = rfsp_pkg::ET_ARRAY;
                            n_mode = rfsp_pkg::MODE_ARRAY;
                        end
                        default: begin
                            n_type     = rfsp_pkg::ET_SIMPLE;
                            res_status = rfsp_pkg::ST_BAD_TAG;
                            do_to_top  = 1'b1;
                        end
                    endcase
                end
                rfsp_pkg::MODE_BODY: begin
                    res_pay = 1'b1;
                    n_bulk  = r_bulk - rfsp_pkg::t_value'(1);
                    if (r_bulk == rfsp_pkg::t_value'(1)) begin
                        n_mode = rfsp_pkg::MODE_TAIL1;
                    end
                end
                rfsp_pkg::MODE_TAIL1: begin
                    n_mode = rfsp_pkg::MODE_TAIL2;
                end
                rfsp_pkg::MODE_TAIL2: begin
                    do_elem_done = 1'b1;
                end
                rfsp_pkg::MODE_SIMPLE, rfsp_pkg::MODE_ERROR, rfsp_pkg::MODE_INT,
                rfsp_pkg::MODE_BULKLEN, rfsp_pkg::MODE_NULL, rfsp_pkg::MODE_ARRAY: begin
                    if (r_mode == rfsp_pkg::MODE_BULKLEN && r_phase == rfsp_pkg::PH_NONE
                            && !r_saw_cr && w_b == rfsp_pkg::CH_MINUS) begin
                        n_mode  = rfsp_pkg::MODE_NULL;
                        n_type  = rfsp_pkg::ET_NULL;
                        n_phase = rfsp_pkg::PH_NONE;
                        res_pay = 1'b1;
                    end else if (r_saw_cr && w_b == rfsp_pkg::CH_LF) begin
                        // end of line
                        n_saw_cr = 1'b0;
                        if (r_mode == rfsp_pkg::MODE_SIMPLE
                                || r_mode == rfsp_pkg::MODE_ERROR) begin
                            do_elem_done = 1'b1;
                        end else if (r_mode == rfsp_pkg::MODE_NULL) begin
                            if (r_phase == rfsp_pkg::PH_DIGITS) begin
                                do_elem_done = 1'b1;
                            end else begin
                                res_status = rfsp_pkg::ST_BAD_NULL;
                                do_to_top  = 1'b1;
                            end
                        end else if (r_phase == rfsp_pkg::PH_NONE
                                || r_phase == rfsp_pkg::PH_INVALID || r_ovf) begin
                            res_status = rfsp_pkg::ST_BAD_NUM;
                            do_to_top  = 1'b1;
                        end else begin
                            res_value = r_acc;
                            if (r_mode == rfsp_pkg::MODE_INT) begin
                                do_elem_done = 1'b1;
                            end else if (r_mode == rfsp_pkg::MODE_BULKLEN) begin
                                n_acc   = '0;
                                n_phase = rfsp_pkg::PH_NONE;
                                n_ovf   = 1'b0;
                                n_bulk  = r_acc;
                                n_mode  = (r_acc != '0) ? rfsp_pkg::MODE_BODY
                                                        : rfsp_pkg::MODE_TAIL1;
                            end else if (r_acc == '0) begin
                                do_elem_done = 1'b1;
                            end else if (r_depth >= MAX_D) begin
                                res_value  = '0;
                                res_status = rfsp_pkg::ST_TOO_DEEP;
                                do_to_top  = 1'b1;
                            end else begin
                                // push: old top goes to ram, new count is the top
                                ram_we      = (r_depth != '0);
                                n_top_cnt   = r_acc;
                                n_top_chain = (r_depth != '0
                                               && r_top_cnt == rfsp_pkg::t_value'(1))
                                            ? r_top_chain + ONE_D : '0;
                                n_depth     = r_depth + ONE_D;
                                n_acc       = '0;
                                n_phase     = rfsp_pkg::PH_NONE;
                                n_ovf       = 1'b0;
                                n_bulk      = '0;
                                n_mode      = rfsp_pkg::MODE_TAG;
                            end
                        end
                    end else begin
                        n_saw_cr = (w_b == rfsp_pkg::CH_CR);
                        n_phase  = w_ph;
                        if (w_b != rfsp_pkg::CH_CR) begin
                            res_pay = 1'b1;
                            if (r_mode == rfsp_pkg::MODE_NULL) begin
                                n_phase = (w_ph == rfsp_pkg::PH_NONE
                                           && w_b == rfsp_pkg::CH_ONE)
                                        ? rfsp_pkg::PH_DIGITS : rfsp_pkg::PH_INVALID;
                            end else if (w_numeric && (w_ph == rfsp_pkg::PH_NONE
                                    || w_ph == rfsp_pkg::PH_DIGITS)) begin
                                if (w_is_digit) begin
                                    n_phase = rfsp_pkg::PH_DIGITS;
                                    if (r_ovf || w_ovf_now) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_acc = w_prod[rfsp_pkg::VALUE_W-1:0];
                                    end
                                end else begin
                                    n_phase = (w_ph == rfsp_pkg::PH_NONE)
                                            ? rfsp_pkg::PH_INVALID : rfsp_pkg::PH_AFTER;
                                end
                            end
                        end
                    end
                end
                default: begin
                    do_to_top = 1'b1;
                end
            endcase

            if (do_to_top || do_elem_done) begin
                n_acc    = '0;
                n_phase  = rfsp_pkg::PH_NONE;
                n_ovf    = 1'b0;
                n_saw_cr = 1'b0;
                n_bulk   = '0;
                n_mode   = rfsp_pkg::MODE_TAG;
            end
            if (do_to_top) begin
                n_depth = '0;
            end
            if (do_elem_done) begin
                if (r_depth == '0) begin
                    res_status = rfsp_pkg::ST_FRAME_DONE;
                end else if (r_top_cnt != rfsp_pkg::t_value'(1)) begin
                    n_top_cnt  = r_top_cnt - rfsp_pkg::t_value'(1);
                    res_status = rfsp_pkg::ST_ELEM_DONE;
                end else begin
                    // pop the top and every exhausted level below it at once
                    n_depth = w_newdepth;
                    if (w_newdepth == '0) begin
                        res_status = rfsp_pkg::ST_FRAME_DONE;
                    end else begin
                        res_status  = rfsp_pkg::ST_ELEM_DONE;
                        ram_re      = 1'b1;
                        n_load_pend = 1'b1;
                    end
                end
            end
        end
    end

    assign w_depth_ext = {5'b0, n_depth};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= rfsp_pkg::MODE_TAG;
            r_phase     <= rfsp_pkg::PH_NONE;
            r_acc       <= '0;
            r_bulk      <= '0;
            r_type      <= rfsp_pkg::ET_SIMPLE;
            r_ovf       <= 1'b0;
            r_saw_cr    <= 1'b0;
            r_depth     <= '0;
            r_load_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_bulk      <= n_bulk;
            r_type      <= n_type;
            r_ovf       <= n_ovf;
            r_saw_cr    <= n_saw_cr;
            r_depth     <= n_depth;
            r_load_pend <= n_load_pend;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_cnt   <= n_top_cnt;
        r_top_chain <= n_top_chain;
        if (w_accept) begin
            r_out_status <= res_status;
            r_out_type   <= n_type;
            r_out_value  <= res_value;
            r_out_depth  <= w_depth_ext[4:0];
            r_out_pay    <= res_pay;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out_status;
    assign o_res.elem_type     = r_out_type;
    assign o_res.value         = r_out_value;
    assign o_res.nest_depth    = r_out_depth;
    assign o_res.payload_valid = r_out_pay;

    // a refill only follows a pop, which always leaves the parser expecting a tag
    a_refill_at_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_pend |-> r_mode == rfsp_pkg::MODE_TAG)
        else $error("top refill pending outside tag state");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= MAX_D)
        else $error("stack depth beyond limit");

    a_chain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0 && !r_load_pend) |-> (r_top_chain < r_depth && r_top_cnt != '0))
        else $error("top entry inconsistent with stack depth");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == rfsp_pkg::MODE_BODY |-> r_bulk != '0)
        else $error("bulk body with no bytes left");

    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status >= rfsp_pkg::ST_BAD_TAG)
            |-> (r_out_depth == '0 && r_out_value == '0))
        else $error("error result with nonzero depth or value");

endmodule
`default_nettype wire
